### hdl/virtqueue_rx_used_ring_consumer_top_defines.svh
// Assertion macros shared by the receive used-ring consumer.
`ifndef VIRTQUEUE_RX_USED_RING_CONSUMER_TOP_DEFINES_SVH
`define VIRTQUEUE_RX_USED_RING_CONSUMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define VQRX_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vqrx assertion failed");

`define VQRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vqrx assertion failed");

`else

`define VQRX_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define VQRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/vqrx_pkg.sv
package vqrx_pkg;

	localparam int BUFFER_COUNT_DEF = 16;
	localparam int BUFFER_BYTES_DEF = 2048;

	localparam logic [31:0] HDR_BYTES     = 32'd10;
	localparam logic [31:0] ETH_HDR_BYTES = 32'd14;
	localparam logic [31:0] FRAME_MAX     = 32'd1514;
	localparam logic [31:0] RUNT_LIMIT    = HDR_BYTES + ETH_HDR_BYTES;

	localparam logic [3:0] QLOG_MAX = 4'd8;
	localparam logic [3:0] QLOG_RESET = 4'd8;

	typedef logic [2:0] status_t;

	localparam status_t ST_DELIVERED = 3'd0;
	localparam status_t ST_BAD_ID    = 3'd1;
	localparam status_t ST_RUNT      = 3'd2;
	localparam status_t ST_OVERSIZE  = 3'd3;
	localparam status_t ST_NOT_READY = 3'd4;

	typedef struct packed {
		logic       enabled;
		logic [3:0] queue_size_log2;
	} cfg_t;

	typedef struct packed {
		logic [31:0] entry_id;
		logic [31:0] entry_len;
		logic [15:0] capacity;
	} item_t;

endpackage

### hdl/virtqueue_rx_used_ring_consumer_top.sv
// Channel   Handshake                     Word
// entry     entry_valid / entry_ready     entry_id, entry_len, capacity
// result    result_valid / result_ready   status, lengths, recycle info, totals
// config    APB psel/penable/pwrite       enabled @0x0, queue_size_log2 @0x4
//
// One entry per cycle unless the result stalls; each entry passes the input register first.
// Input register, then classify and update indices and counters into the result register.
// A stalled result holds; one more entry is taken into the input register meanwhile.
// Reset: device disabled, ring size 256, used index 0, available index BUFFER_COUNT.
`include "virtqueue_rx_used_ring_consumer_top_defines.svh"

module virtqueue_rx_used_ring_consumer_top #(
	parameter int BUFFER_COUNT = vqrx_pkg::BUFFER_COUNT_DEF,
	parameter int BUFFER_BYTES = vqrx_pkg::BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        entry_valid,
	output logic        entry_ready,
	input  logic [31:0] entry_id,
	input  logic [31:0] entry_len,
	input  logic [15:0] capacity,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  status,
	output logic [10:0] payload_length,
	output logic [10:0] copy_length,
	output logic        recycle,
	output logic [3:0]  recycle_id,
	output logic [7:0]  recycle_slot,
	output logic [7:0]  used_slot,
	output logic [31:0] packets_total,
	output logic [31:0] bytes_total,
	output logic [31:0] errors_total,
	output logic [31:0] dropped_total
);
	import vqrx_pkg::*;

	cfg_t  cfg;
	item_t entry_in;
	item_t item_s1;
	logic  valid_s1;
	logic  take;

	assign entry_in.entry_id = entry_id;
	assign entry_in.entry_len = entry_len;
	assign entry_in.capacity = capacity;

	vqrx_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vqrx_entry_stage u_entry (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (entry_valid),
		.entry_ready (entry_ready),
		.entry_in    (entry_in),
		.take        (take),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1)
	);

	vqrx_core #(
		.BUFFER_COUNT (BUFFER_COUNT),
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1),
		.take            (take),
		.valid_s2        (result_valid),
		.result_ready    (result_ready),
		.status_s2       (status),
		.payload_s2      (payload_length),
		.copy_s2         (copy_length),
		.recycle_s2      (recycle),
		.recycle_id_s2   (recycle_id),
		.recycle_slot_s2 (recycle_slot),
		.used_slot_s2    (used_slot),
		.packet_count_q  (packets_total),
		.byte_count_q    (bytes_total),
		.error_count_q   (errors_total),
		.drop_count_q    (dropped_total)
	);

	`VQRX_ASSERT_IMPLIES(a_recycle_status, clk, arst_n, result_valid && recycle,
		status == ST_DELIVERED || status == ST_RUNT || status == ST_OVERSIZE)
	`VQRX_ASSERT_IMPLIES(a_copy_le_payload, clk, arst_n, result_valid,
		copy_length <= payload_length)
	`VQRX_ASSERT_IMPLIES(a_not_ready_quiet, clk, arst_n,
		result_valid && status == ST_NOT_READY, !recycle && used_slot == 8'd0)
	`VQRX_ASSERT_NEXT(a_stall_hold, clk, arst_n,
		valid_s1 && result_valid && !result_ready, valid_s1 && result_valid)

endmodule

### hdl/vqrx_apb_regs.sv
module vqrx_apb_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output vqrx_pkg::cfg_t    cfg
);
	import vqrx_pkg::*;

	localparam logic REG_ENABLED = 1'b0;
	localparam logic REG_QLOG    = 1'b1;

	logic       enabled_q;
	logic [3:0] qlog_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			qlog_q <= QLOG_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ENABLED: enabled_q <= pwdata[0];
				REG_QLOG:    qlog_q <= pwdata[3:0];
				default:     enabled_q <= enabled_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ENABLED: prdata = {31'd0, enabled_q};
			REG_QLOG:    prdata = {28'd0, qlog_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign cfg.enabled = enabled_q;
	assign cfg.queue_size_log2 = qlog_q;

endmodule

### hdl/vqrx_entry_stage.sv
module vqrx_entry_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            entry_valid,
	output logic            entry_ready,
	input  vqrx_pkg::item_t entry_in,
	input  logic            take,
	output logic            valid_s1,
	output vqrx_pkg::item_t item_s1
);
	import vqrx_pkg::*;

	logic load;

	assign entry_ready = !valid_s1 || take;
	assign load = entry_valid && entry_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= entry_in;
		end
	end

endmodule

### hdl/vqrx_core.sv
module vqrx_core #(
	parameter int BUFFER_COUNT = vqrx_pkg::BUFFER_COUNT_DEF,
	parameter int BUFFER_BYTES = vqrx_pkg::BUFFER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vqrx_pkg::cfg_t    cfg,
	input  logic              valid_s1,
	input  vqrx_pkg::item_t   item_s1,
	output logic              take,
	output logic              valid_s2,
	input  logic              result_ready,
	output vqrx_pkg::status_t status_s2,
	output logic [10:0]       payload_s2,
	output logic [10:0]       copy_s2,
	output logic              recycle_s2,
	output logic [3:0]        recycle_id_s2,
	output logic [7:0]        recycle_slot_s2,
	output logic [7:0]        used_slot_s2,
	output logic [31:0]       packet_count_q,
	output logic [31:0]       byte_count_q,
	output logic [31:0]       error_count_q,
	output logic [31:0]       drop_count_q
);
	import vqrx_pkg::*;

	logic [15:0] consumed_index_q;
	logic [15:0] avail_index_q;

	logic        not_ready;
	logic        bad_id;
	logic        runt;
	logic        oversize;
	logic        deliver;
	logic        recycle;
	logic [3:0]  qlog;
	logic [8:0]  mask_wide;
	logic [7:0]  mask;
	logic [31:0] payload_full;
	logic [10:0] payload;
	logic [10:0] copy;
	status_t     status;

	assign take = valid_s1 && (!valid_s2 || result_ready);

	always_comb begin
		qlog = (cfg.queue_size_log2 > QLOG_MAX) ? QLOG_MAX : cfg.queue_size_log2;
		mask_wide = (9'd1 << qlog) - 9'd1;
		mask = mask_wide[7:0];

		not_ready = !cfg.enabled || (item_s1.capacity == 16'd0);
		bad_id = item_s1.entry_id >= 32'(BUFFER_COUNT);
		payload_full = item_s1.entry_len - HDR_BYTES;
		runt = item_s1.entry_len < RUNT_LIMIT;
		oversize = (item_s1.entry_len > 32'(BUFFER_BYTES)) || (payload_full > FRAME_MAX);
		recycle = !not_ready && !bad_id;
		deliver = recycle && !runt && !oversize;

		if (not_ready) begin
			status = ST_NOT_READY;
		end else if (bad_id) begin
			status = ST_BAD_ID;
		end else if (runt) begin
			status = ST_RUNT;
		end else if (oversize) begin
			status = ST_OVERSIZE;
		end else begin
			status = ST_DELIVERED;
		end

		payload = deliver ? payload_full[10:0] : 11'd0;
		if (!deliver) begin
			copy = 11'd0;
		end else if ({5'd0, payload} < item_s1.capacity) begin
			copy = payload;
		end else begin
			copy = item_s1.capacity[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			consumed_index_q <= 16'd0;
			avail_index_q <= 16'(BUFFER_COUNT);
			packet_count_q <= 32'd0;
			byte_count_q <= 32'd0;
			error_count_q <= 32'd0;
			drop_count_q <= 32'd0;
		end else begin
			if (take) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
			if (take && !not_ready) begin
				consumed_index_q <= consumed_index_q + 16'd1;
			end
			if (take && recycle) begin
				avail_index_q <= avail_index_q + 16'd1;
			end
			if (take && deliver) begin
				packet_count_q <= packet_count_q + 32'd1;
				byte_count_q <= byte_count_q + {21'd0, payload};
			end
			if (take && recycle && (runt || oversize)) begin
				error_count_q <= error_count_q + 32'd1;
			end
			if (take && !not_ready && bad_id) begin
				drop_count_q <= drop_count_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_s2 <= status;
			payload_s2 <= payload;
			copy_s2 <= copy;
			recycle_s2 <= recycle;
			recycle_id_s2 <= recycle ? item_s1.entry_id[3:0] : 4'd0;
			recycle_slot_s2 <= recycle ? (avail_index_q[7:0] & mask) : 8'd0;
			used_slot_s2 <= not_ready ? 8'd0 : (consumed_index_q[7:0] & mask);
		end
	end

endmodule

### tb/tb_virtqueue_rx_used_ring_consumer_top.sv
module tb_virtqueue_rx_used_ring_consumer_top;
	import vqrx_pkg::*;

	localparam int BUFS = BUFFER_COUNT_DEF;
	localparam int BUF_BYTES = BUFFER_BYTES_DEF;
	localparam logic [2:0] REG_ENABLED = 3'h0;
	localparam logic [2:0] REG_QUEUE_LOG2 = 3'h4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		status_t     status;
		logic [10:0] payload_length;
		logic [10:0] copy_length;
		logic        recycle;
		logic [3:0]  recycle_id;
		logic [7:0]  recycle_slot;
		logic [7:0]  used_slot;
		logic [31:0] packets;
		logic [31:0] bytes;
		logic [31:0] errors;
		logic [31:0] drops;
	} rx_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        entry_valid = 1'b0;
	logic        entry_ready;
	logic [31:0] entry_id = '0;
	logic [31:0] entry_len = '0;
	logic [15:0] capacity = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  status;
	logic [10:0] payload_length;
	logic [10:0] copy_length;
	logic        recycle;
	logic [3:0]  recycle_id;
	logic [7:0]  recycle_slot;
	logic [7:0]  used_slot;
	logic [31:0] packets_total;
	logic [31:0] bytes_total;
	logic [31:0] errors_total;
	logic [31:0] dropped_total;

	virtqueue_rx_used_ring_consumer_top u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.entry_valid(entry_valid), .entry_ready(entry_ready),
		.entry_id(entry_id), .entry_len(entry_len), .capacity(capacity),
		.result_valid(result_valid), .result_ready(result_ready),
		.status(status), .payload_length(payload_length), .copy_length(copy_length),
		.recycle(recycle), .recycle_id(recycle_id), .recycle_slot(recycle_slot),
		.used_slot(used_slot), .packets_total(packets_total), .bytes_total(bytes_total),
		.errors_total(errors_total), .dropped_total(dropped_total)
	);

	logic        dev_enabled = 1'b0;
	logic [3:0]  ring_log2 = QLOG_RESET;
	logic [15:0] pred_used = 16'd0;
	logic [15:0] pred_avail = 16'(BUFS);
	logic [31:0] packet_cnt = '0;
	logic [31:0] byte_cnt = '0;
	logic [31:0] error_cnt = '0;
	logic [31:0] drop_cnt = '0;

	rx_result_t pending_results[$];
	int         err_count = 0;
	int         cycle_count = 0;
	int         ready_hold = 0;
	bit         idle_on = 1'b1;

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_virtqueue_rx_used_ring_consumer_top: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			result_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			ready_hold = $urandom_range(1, 9) - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			$display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		rx_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", 32'd1, 32'd0);
			end else begin
				want = pending_results.pop_front();
				report_mismatch("status", 32'(status), 32'(want.status));
				report_mismatch("payload_length", 32'(payload_length),
					32'(want.payload_length));
				report_mismatch("copy_length", 32'(copy_length), 32'(want.copy_length));
				report_mismatch("recycle", 32'(recycle), 32'(want.recycle));
				report_mismatch("recycle_id", 32'(recycle_id), 32'(want.recycle_id));
				report_mismatch("recycle_slot", 32'(recycle_slot), 32'(want.recycle_slot));
				report_mismatch("used_slot", 32'(used_slot), 32'(want.used_slot));
				report_mismatch("packets_total", packets_total, want.packets);
				report_mismatch("bytes_total", bytes_total, want.bytes);
				report_mismatch("errors_total", errors_total, want.errors);
				report_mismatch("dropped_total", dropped_total, want.drops);
			end
		end
	end

	function automatic rx_result_t predict_entry(input logic [31:0] id, input logic [31:0] len,
			input logic [15:0] cap);
		rx_result_t r;
		logic [15:0] mask;
		logic [31:0] payload;
		r = '0;
		mask = (16'd1 << ((ring_log2 > QLOG_MAX) ? QLOG_MAX : ring_log2)) - 16'd1;
		if (!dev_enabled || cap == 16'd0) begin
			r.status = ST_NOT_READY;
		end else begin
			r.used_slot = 8'(pred_used & mask);
			pred_used = pred_used + 16'd1;
			if (id >= 32'(BUFS)) begin
				r.status = ST_BAD_ID;
				drop_cnt = drop_cnt + 32'd1;
			end else begin
				if (len < RUNT_LIMIT) begin
					r.status = ST_RUNT;
					error_cnt = error_cnt + 32'd1;
				end else if (len > 32'(BUF_BYTES) || len - HDR_BYTES > FRAME_MAX) begin
					r.status = ST_OVERSIZE;
					error_cnt = error_cnt + 32'd1;
				end else begin
					r.status = ST_DELIVERED;
					payload = len - HDR_BYTES;
					r.payload_length = payload[10:0];
					r.copy_length = (payload < {16'd0, cap}) ? payload[10:0] : cap[10:0];
					packet_cnt = packet_cnt + 32'd1;
					byte_cnt = byte_cnt + payload;
				end
				r.recycle = 1'b1;
				r.recycle_id = id[3:0];
				r.recycle_slot = 8'(pred_avail & mask);
				pred_avail = pred_avail + 16'd1;
			end
		end
		r.packets = packet_cnt;
		r.bytes = byte_cnt;
		r.errors = error_cnt;
		r.drops = drop_cnt;
		return r;
	endfunction

	task automatic send_entry(input logic [31:0] id, input logic [31:0] len,
			input logic [15:0] cap);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			entry_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		entry_valid <= 1'b1;
		entry_id <= id;
		entry_len <= len;
		capacity <= cap;
		do @(posedge clk); while (!entry_ready);
		pending_results.push_back(predict_entry(id, len, cap));
	endtask

	task automatic wait_results_drained();
		entry_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_ENABLED)
			dev_enabled = data[0];
		else if (addr == REG_QUEUE_LOG2)
			ring_log2 = data[3:0];
	endtask

	function automatic void rand_entry(output logic [31:0] id, output logic [31:0] len,
			output logic [15:0] cap);
		case ($urandom_range(0, 9))
			0: id = $urandom;
			1: id = 32'(BUFS) + $urandom_range(0, 15);
			default: id = $urandom_range(0, BUFS - 1);
		endcase
		case ($urandom_range(0, 11))
			0: len = $urandom;
			1: len = $urandom_range(0, 23);
			2: len = $urandom_range(1525, 2100);
			3: len = $urandom_range(20, 28);
			4: len = $urandom_range(1520, 1530);
			default: len = $urandom_range(24, 1524);
		endcase
		case ($urandom_range(0, 11))
			0: cap = 16'd0;
			1: cap = 16'($urandom_range(1, 64));
			2: cap = 16'hFFFF;
			default: cap = 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input int count);
		logic [31:0] id;
		logic [31:0] len;
		logic [15:0] cap;
		repeat (count) begin
			rand_entry(id, len, cap);
			send_entry(id, len, cap);
		end
	endtask

	task automatic test_refused_when_down();
		send_entry(32'd3, 32'd100, 16'd50);
		send_entry(32'd4, 32'd100, 16'd0);
		wait_results_drained();
		write_reg(REG_ENABLED, 32'd1);
	endtask

	task automatic test_frame_classes();
		send_entry(32'd0, 32'd24, 16'd1);
		send_entry(32'd15, 32'd1524, 16'hFFFF);
		send_entry(32'd1, 32'd23, 16'd100);
		send_entry(32'd2, 32'd0, 16'd100);
		send_entry(32'd3, 32'd1525, 16'd100);
		send_entry(32'd4, 32'd2048, 16'd100);
		send_entry(32'd5, 32'd2049, 16'd100);
		send_entry(32'd6, 32'hFFFF_FFFF, 16'hFFFF);
		send_entry(32'(BUFS), 32'd100, 16'd100);
		send_entry(32'hFFFF_FFFF, 32'd100, 16'd100);
		send_entry(32'd7, 32'd500, 16'd100);
		send_entry(32'd8, 32'd110, 16'd200);
		send_entry(32'd9, 32'd110, 16'd100);
		send_entry(32'd10, 32'd100, 16'd0);
		send_entry(32'd11, 32'd24, 16'hFFFF);
		wait_results_drained();
		write_reg(REG_ENABLED, 32'd0);
		send_entry(32'd0, 32'd100, 16'd5);
		wait_results_drained();
		write_reg(REG_ENABLED, 32'd1);
	endtask

	task automatic test_ring_sizes();
		logic [3:0] sizes[7];
		sizes = '{4'd0, 4'd1, 4'd3, 4'd4, 4'd8, 4'd9, 4'd15};
		foreach (sizes[i]) begin
			wait_results_drained();
			write_reg(REG_QUEUE_LOG2, {28'd0, sizes[i]});
			send_random(20);
		end
	endtask

	task automatic test_random_traffic();
		repeat (8) begin
			wait_results_drained();
			write_reg(REG_ENABLED, ($urandom_range(0, 5) != 0) ? 32'd1 : 32'd0);
			write_reg(REG_QUEUE_LOG2, $urandom_range(0, 15));
			send_random(120);
		end
	endtask

	task automatic test_back_to_back();
		wait_results_drained();
		idle_on = 1'b0;
		write_reg(REG_ENABLED, 32'd1);
		write_reg(REG_QUEUE_LOG2, 32'(QLOG_MAX));
		send_random(150);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_refused_when_down();
		test_frame_classes();
		test_ring_sizes();
		test_random_traffic();
		test_back_to_back();
		wait_results_drained();
		repeat (8) @(posedge clk);
		report_mismatch("results left pending", pending_results.size(), 32'd0);
		if (err_count == 0)
			$display("tb_virtqueue_rx_used_ring_consumer_top: clean");
		else
			$display("tb_virtqueue_rx_used_ring_consumer_top: errors");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/vqrx_pkg.sv
hdl/vqrx_apb_regs.sv
hdl/vqrx_entry_stage.sv
hdl/vqrx_core.sv
hdl/virtqueue_rx_used_ring_consumer_top.sv
tb/tb_virtqueue_rx_used_ring_consumer_top.sv
